FILE: design/clrf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package clrf_pkg;

  localparam int MASK_W  = 64;
  localparam int LAYER_W = 6;
  localparam int CLASS_W = 2;
  localparam int ID_W    = 8;

  typedef enum logic [1:0] {
    OP_ACQUIRE    = 2'd0,
    OP_PAIR       = 2'd1,
    OP_BROADPHASE = 2'd2,
    OP_QUERY      = 2'd3
  } opcode_t;

  localparam logic [CLASS_W-1:0] CLASS_CHARACTER = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_SOFT      = 2'd2;

  typedef struct packed {
    logic [MASK_W-1:0]  mask;
    logic [LAYER_W-1:0] layer;
    logic               moves;
    logic [CLASS_W-1:0] cls;
  } entry_t;

  // built-in entries: id 0 static catch-all, id 1 moving catch-all
  localparam entry_t ENTRY_STATIC = '{mask: '1, layer: '0, moves: 1'b0, cls: '0};
  localparam entry_t ENTRY_MOVING = '{mask: '1, layer: '0, moves: 1'b1, cls: '0};
  // view of an id that is not registered
  localparam entry_t ENTRY_NONE   = '{mask: '0, layer: '0, moves: 1'b0, cls: '0};

endpackage
`default_nettype wire

FILE: design/collision_layer_registry_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// collision layer registry and filter
//
// input channel s_*: one item per request, opcode in s_tuser selects acquire,
// pair filter, object versus broadphase or query mask match. output channel
// m_*: exactly one item per request carrying the id and the filter flags.
//
// entries live in a single synchronous ram with a registered read;
// ids 0 and 1 are the built-in static and moving entries and are not stored.
// broadphase and query mask read one entry, while pair filter makes two
// reads of the same ram port; an acquire scan reads one entry per cycle
// from id 0 and stops at the matching id on a hit or at count on a miss.
// one request is in flight at a time; s_tready rises in the cycle after the
// result is loaded.
//
// reset: synchronous, clears the handshake state and sets the count to two
// (only the built-in entries); no ram clearing is needed.
// stall: the result sits in the output register while m_tready is low; a new
// request can still be accepted and waits on that register before finishing.
module collision_layer_registry_filter #(
  parameter int MAX_LAYERS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // group_mask[63:0], layer_index[69:64], is_moving[70], body_class[72:71],
  // first_layer[80:73], second_layer[88:81], broadphase_is_moving[89], zero fill
  input  wire logic [95:0] s_tdata,
  // opcode[1:0]
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // layer_id[7:0], collide[8], first_in_moving_tree[9], table_full[10],
  // unknown_layer[11], zero fill
  output logic [15:0]      m_tdata
);
  import clrf_pkg::*;

  localparam int AW = $clog2(MAX_LAYERS);
  localparam int CW = $clog2(MAX_LAYERS + 1);
  localparam int XW = (CW > ID_W) ? CW : ID_W;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIRST, S_SECOND} state_t;

  state_t          state;
  logic [CW-1:0]   count;
  logic [CW-1:0]   scan;
  opcode_t         op;
  entry_t          req;
  logic [ID_W-1:0] first_id;
  logic [ID_W-1:0] second_id;
  logic            bp_moving;
  entry_t          first_ent;

  logic [ID_W-1:0] res_id;
  logic            res_collide;
  logic            res_first_moving;
  logic            res_full;
  logic            res_unknown;

  // input unpack
  opcode_t         in_op;
  entry_t          in_entry;
  logic [XW-1:0]   in_first_x;

  logic            accept;
  logic            out_free;
  logic            res_load;
  logic [XW-1:0]   count_x;
  logic [XW-1:0]   first_x;
  logic [XW-1:0]   second_x;
  logic [XW-1:0]   scan_id_x;
  logic            unk1;
  logic            unk2;
  logic            hit;
  logic            scan_done;
  logic            table_full_now;
  entry_t          view_a;
  entry_t          view_b;

  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  entry_t          rd_entry;
  logic            wr_en;

  function automatic logic pair_ok(entry_t a, entry_t b);
    logic char_soft;
    char_soft = (a.cls == CLASS_CHARACTER && b.cls == CLASS_SOFT) ||
                (a.cls == CLASS_SOFT && b.cls == CLASS_CHARACTER);
    if (!a.moves && !b.moves) begin
      return 1'b0;
    end
    if (char_soft) begin
      return 1'b0;
    end
    return a.mask[b.layer] && b.mask[a.layer];
  endfunction

  assign in_op          = opcode_t'(s_tuser);
  assign in_entry.mask  = s_tdata[63:0];
  assign in_entry.layer = s_tdata[69:64];
  assign in_entry.moves = s_tdata[70];
  assign in_entry.cls   = s_tdata[72:71];
  assign in_first_x     = XW'(s_tdata[80:73]);

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign count_x   = XW'(count);
  assign first_x   = XW'(first_id);
  assign second_x  = XW'(second_id);
  assign scan_id_x = XW'(scan - CW'(1));
  assign unk1      = (first_x >= count_x);
  assign unk2      = (second_x >= count_x);

  // the scan compares the registered read of id scan - 1
  assign hit            = (rd_entry == req);
  assign scan_done      = (scan == count);
  assign table_full_now = (count >= CW'(MAX_LAYERS));

  assign view_a = unk1 ? ENTRY_NONE : rd_entry;
  assign view_b = unk2 ? ENTRY_NONE : rd_entry;

  // a result goes into the output register this cycle
  assign res_load = out_free && (((state == S_SCAN) && (hit || scan_done)) ||
                                 ((state == S_FIRST) && (op != OP_PAIR)) ||
                                 (state == S_SECOND));

  // ram port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = in_first_x[AW-1:0];
    wr_en   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          rd_en   = 1'b1;
          rd_addr = (in_op == OP_ACQUIRE) ? '0 : in_first_x[AW-1:0];
        end
      end
      S_SCAN: begin
        if (!hit && !scan_done) begin
          rd_en   = 1'b1;
          rd_addr = scan[AW-1:0];
        end
        if (!hit && scan_done && out_free && !table_full_now) begin
          wr_en = 1'b1;
        end
      end
      S_FIRST: begin
        if (op == OP_PAIR) begin
          rd_en   = 1'b1;
          rd_addr = second_x[AW-1:0];
        end
      end
      S_SECOND: begin
      end
      default: begin
      end
    endcase
  end

  clrf_entry_store #(
    .MAX_LAYERS (MAX_LAYERS)
  ) u_store (
    .clk      (clk),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry),
    .wr_en    (wr_en),
    .wr_addr  (count[AW-1:0]),
    .wr_entry (req)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= CW'(2);
      m_tvalid <= 1'b0;
    end else begin
      if (res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op        <= in_op;
            req       <= in_entry;
            first_id  <= s_tdata[80:73];
            second_id <= s_tdata[88:81];
            bp_moving <= s_tdata[89];
            scan      <= CW'(1);
            state     <= (in_op == OP_ACQUIRE) ? S_SCAN : S_FIRST;
          end
        end
        S_SCAN: begin
          if (hit) begin
            if (out_free) begin
              res_id           <= scan_id_x[ID_W-1:0];
              res_collide      <= 1'b0;
              res_first_moving <= 1'b0;
              res_full         <= 1'b0;
              res_unknown      <= 1'b0;
              state            <= S_IDLE;
            end
          end else if (scan_done) begin
            if (out_free) begin
              res_collide      <= 1'b0;
              res_first_moving <= 1'b0;
              res_unknown      <= 1'b0;
              state            <= S_IDLE;
              if (table_full_now) begin
                // fallback to the built-in entry that matches the motion
                res_id   <= ID_W'(req.moves);
                res_full <= 1'b1;
              end else begin
                res_id   <= count_x[ID_W-1:0];
                res_full <= 1'b0;
                count    <= count + CW'(1);
              end
            end
          end else begin
            scan <= scan + CW'(1);
          end
        end
        S_FIRST: begin
          if (op == OP_PAIR) begin
            first_ent <= view_a;
            state     <= S_SECOND;
          end else if (out_free) begin
            res_id           <= '0;
            res_first_moving <= view_a.moves;
            res_full         <= 1'b0;
            res_unknown      <= unk1;
            res_collide      <= (op == OP_BROADPHASE) ? (view_a.moves || bp_moving)
                                                      : req.mask[view_a.layer];
            state            <= S_IDLE;
          end
        end
        S_SECOND: begin
          if (out_free) begin
            res_id           <= '0;
            res_first_moving <= first_ent.moves;
            res_full         <= 1'b0;
            res_unknown      <= unk1 || unk2;
            res_collide      <= pair_ok(first_ent, view_b);
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {4'b0000, res_unknown, res_full, res_first_moving, res_collide, res_id};

endmodule
`default_nettype wire

FILE: design/clrf_entry_store.sv
`timescale 1ns / 1ps
`default_nettype none
module clrf_entry_store #(
  parameter int MAX_LAYERS = 256,
  localparam int AW = $clog2(MAX_LAYERS)
) (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output clrf_pkg::entry_t      rd_entry,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire clrf_pkg::entry_t wr_entry
);
  import clrf_pkg::*;

  entry_t mem [MAX_LAYERS];
  entry_t rd_data;
  logic   rd_builtin;
  logic   rd_one;

  // ids 0 and 1 are fixed entries and never written
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_data    <= mem[rd_addr];
      rd_builtin <= ({1'b0, rd_addr} < (AW + 1)'(2));
      rd_one     <= (rd_addr == AW'(1));
    end
  end

  assign rd_entry = rd_builtin ? (rd_one ? ENTRY_MOVING : ENTRY_STATIC) : rd_data;

endmodule
`default_nettype wire

FILE: design/clrf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module clrf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata
);

  // one request at a time: no back-to-back accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item accepted while one is in flight");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // fallback only yields a built-in id and never comes with query flags
  a_full_fallback: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[10] |-> m_tdata[7:1] == 7'd0 && !m_tdata[11] && !m_tdata[8])
    else $error("bad fallback result");

  a_unknown_query: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[11] |-> m_tdata[7:0] == 8'd0 && !m_tdata[10])
    else $error("unknown id flag on an acquire result");

endmodule

bind collision_layer_registry_filter clrf_checker u_clrf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire
